FILE: src/ttpr_pkg.sv
// shared types and constants of the transposition table probe/replace block
package ttpr_pkg;

  localparam int TAG_W        = 16;
  localparam int TAG_LSB      = 48;
  localparam int BUCKET_OUT_W = 10;

  localparam logic [7:0] AGE_RESET       = 8'd0;
  localparam logic [7:0] AGE_FIELD_RESET = 8'd248;

  typedef enum logic [1:0] {
    CMD_PROBE   = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_STORE   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_CURRENT_AGE = 1'b0,
    CFG_AGE_FIELD   = 1'b1
  } cfg_idx_t;

  // one way of a bucket; tag zero means empty
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic signed [7:0]  depth;
    logic [7:0]         flags;
  } entry_t;

  // classified command as it sits in the queue (bucket travels beside it)
  typedef struct packed {
    cmd_t                    cmd;
    logic [TAG_W-1:0]        tag;
    logic [1:0]              store_way;
    logic signed [7:0]       store_depth;
    logic [7:0]              store_flags;
    logic [BUCKET_OUT_W-1:0] bucket_index;
  } item_t;

  typedef struct packed {
    logic [7:0] current_age;
    logic [7:0] age_field;
  } age_cfg_t;

endpackage

FILE: src/ttpr_in_if.sv
// command channel: valid/ready handshake with the command payload
interface ttpr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [63:0]       position_key;
  logic [1:0]        store_way;
  logic signed [7:0] store_depth;
  logic [7:0]        store_flags;

  modport source (
    output valid, command, position_key, store_way, store_depth, store_flags,
    input  ready
  );
  modport sink (
    input  valid, command, position_key, store_way, store_depth, store_flags,
    output ready
  );
endinterface

FILE: src/ttpr_out_if.sv
// result channel: valid/ready handshake with the result payload
interface ttpr_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic [1:0]        chosen_way;
  logic [9:0]        bucket_index;
  logic signed [7:0] entry_depth;
  logic [7:0]        entry_flags;

  modport source (
    output valid, found, chosen_way, bucket_index, entry_depth, entry_flags,
    input  ready
  );
  modport sink (
    input  valid, found, chosen_way, bucket_index, entry_depth, entry_flags,
    output ready
  );
endinterface

FILE: src/ttpr_front.sv
// front end: takes commands, splits the key into bucket and tag, feeds the queue
module ttpr_front #(
  parameter int BUCKET_BITS = 10
) (
  ttpr_in_if.sink                                      in_ch,
  input  logic                                         init_done,
  input  logic                                         q_full,
  output logic                                         push,
  output logic [$bits(ttpr_pkg::item_t)+BUCKET_BITS-1:0] push_data
);
  import ttpr_pkg::*;

  item_t                  item;
  logic [BUCKET_BITS-1:0] bucket;

  // no transfer until the store has been swept after reset
  assign in_ch.ready = init_done && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    bucket            = in_ch.position_key[BUCKET_BITS-1:0];
    item.cmd          = cmd_t'(in_ch.command);
    item.tag          = in_ch.position_key[TAG_LSB +: TAG_W];
    item.store_way    = in_ch.store_way;
    item.store_depth  = in_ch.store_depth;
    item.store_flags  = in_ch.store_flags;
    item.bucket_index = BUCKET_OUT_W'(bucket);
  end

  assign push_data = {item, bucket};

endmodule

FILE: src/ttpr_queue.sv
// two-entry queue between front and back end
module ttpr_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] pop_data
);
  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop && valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/ttpr_back.sv
// back end: bucket read-modify-write, replacement choice, clear sweep, result register
module ttpr_back #(
  parameter int BUCKET_BITS = 10,
  parameter int WAYS        = 3
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  ttpr_pkg::age_cfg_t                              cfg,
  input  logic                                            q_valid,
  input  logic [$bits(ttpr_pkg::item_t)+BUCKET_BITS-1:0]  q_data,
  output logic                                            q_pop,
  output logic                                            init_done,
  ttpr_out_if.source                                      out_ch
);
  import ttpr_pkg::*;

  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef entry_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CLEAR
  } state_t;

  state_t                 state_r;
  logic [BUCKET_BITS-1:0] cnt_r;
  item_t                  cur_item_r;
  logic [BUCKET_BITS-1:0] cur_bucket_r;
  row_t                   rd_row_r;
  row_t                   mem [NUM_BUCKETS];

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [1:0]             out_way_r;
  logic [9:0]             out_bucket_r;
  logic signed [7:0]      out_depth_r;
  logic [7:0]             out_flags_r;

  item_t                  q_item;
  logic [BUCKET_BITS-1:0] q_bucket;
  logic                   out_free;
  logic                   issue;
  logic                   rd_en;
  logic                   res_load;

  logic                   wr_en;
  logic [BUCKET_BITS-1:0] wr_addr;
  row_t                   wr_row;

  logic                   res_found;
  logic [1:0]             res_way;
  logic signed [7:0]      res_depth;
  logic [7:0]             res_flags;

  function automatic logic signed [9:0] rank_of(entry_t e, logic [7:0] age,
                                                logic [7:0] m);
    logic [7:0] rel;
    rel = (age - (e.flags & m)) & m;
    return $signed({{2{e.depth[7]}}, e.depth}) - $signed({2'b00, rel});
  endfunction

  assign q_item   = item_t'(q_data[$bits(q_data)-1 -: $bits(item_t)]);
  assign q_bucket = q_data[BUCKET_BITS-1:0];

  // one item in flight; start only when its result slot will be empty
  assign out_free  = !out_valid_r || out_ch.ready;
  assign issue     = (state_r == S_IDLE) && q_valid && out_free;
  assign q_pop     = issue;
  assign rd_en     = issue && (q_item.cmd != CMD_CLEAR);
  assign init_done = (state_r != S_INIT);
  assign res_load  = (state_r == S_EXEC) || ((state_r == S_CLEAR) && (&cnt_r));

  // bucket evaluation on the row read in the previous cycle
  always_comb begin
    logic                    hit_found;
    logic [WAY_W-1:0]        hit_idx;
    logic                    repl_found;
    logic [WAY_W-1:0]        repl_idx;
    logic [WAY_W-1:0]        best_idx;
    logic signed [9:0]       best_rank;
    logic signed [9:0]       r;
    logic [WAY_W-1:0]        pick;
    logic [7:0]              fl;
    logic                    way_ok;
    logic [WAY_W-1:0]        st_idx;
    entry_t                  e;

    hit_found  = 1'b0;
    hit_idx    = '0;
    repl_found = 1'b0;
    repl_idx   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit_found && rd_row_r[i].tag == cur_item_r.tag) begin
        hit_found = 1'b1;
        hit_idx   = WAY_W'(i);
      end
      if (!repl_found && (rd_row_r[i].tag == '0 || rd_row_r[i].tag == cur_item_r.tag)) begin
        repl_found = 1'b1;
        repl_idx   = WAY_W'(i);
      end
    end

    // earliest way with the least depth minus relative age
    best_idx  = '0;
    best_rank = rank_of(rd_row_r[0], cfg.current_age, cfg.age_field);
    for (int i = 1; i < WAYS; i++) begin
      r = rank_of(rd_row_r[i], cfg.current_age, cfg.age_field);
      if (best_rank > r) begin
        best_rank = r;
        best_idx  = WAY_W'(i);
      end
    end

    // age refresh of a probe hit
    e  = rd_row_r[hit_idx];
    fl = e.flags;
    if ((fl & cfg.age_field) != cfg.current_age) begin
      fl = cfg.current_age + (fl & ~cfg.age_field);
    end

    way_ok = (32'(cur_item_r.store_way) < WAYS);
    st_idx = WAY_W'(cur_item_r.store_way);
    pick   = repl_found ? repl_idx : best_idx;

    wr_row    = rd_row_r;
    wr_en     = 1'b0;
    res_found = 1'b0;
    res_way   = 2'd0;
    res_depth = '0;
    res_flags = '0;

    case (cur_item_r.cmd)
      CMD_PROBE: begin
        if (hit_found) begin
          res_found              = 1'b1;
          res_way                = 2'(hit_idx);
          res_depth              = e.depth;
          res_flags              = fl;
          wr_row[hit_idx].flags  = fl;
          wr_en                  = 1'b1;
        end
      end
      CMD_REPLACE: begin
        res_found = repl_found;
        res_way   = 2'(pick);
        res_depth = rd_row_r[pick].depth;
        res_flags = rd_row_r[pick].flags;
      end
      CMD_STORE: begin
        res_way = cur_item_r.store_way;
        if (way_ok) begin
          res_found            = 1'b1;
          res_depth            = cur_item_r.store_depth;
          res_flags            = cur_item_r.store_flags;
          wr_row[st_idx].tag   = cur_item_r.tag;
          wr_row[st_idx].depth = cur_item_r.store_depth;
          wr_row[st_idx].flags = cur_item_r.store_flags;
          wr_en                = 1'b1;
        end
      end
      default: begin
      end
    endcase

    wr_addr = cur_bucket_r;
    if (state_r != S_EXEC) begin
      wr_en   = 1'b0;
      wr_addr = cnt_r;
      wr_row  = '0;
    end
    if (state_r == S_INIT || state_r == S_CLEAR) begin
      wr_en = 1'b1;
    end
  end

  // bucket memory: one row per bucket
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[q_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          cnt_r <= cnt_r + BUCKET_BITS'(1);
          if (&cnt_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (issue) begin
            cur_item_r   <= q_item;
            cur_bucket_r <= q_bucket;
            state_r      <= (q_item.cmd == CMD_CLEAR) ? S_CLEAR : S_EXEC;
          end
        end
        S_EXEC: begin
          out_found_r  <= res_found;
          out_way_r    <= res_way;
          out_bucket_r <= cur_item_r.bucket_index;
          out_depth_r  <= res_depth;
          out_flags_r  <= res_flags;
          state_r      <= S_IDLE;
        end
        S_CLEAR: begin
          cnt_r <= cnt_r + BUCKET_BITS'(1);
          if (&cnt_r) begin
            out_found_r  <= 1'b0;
            out_way_r    <= 2'd0;
            out_bucket_r <= cur_item_r.bucket_index;
            out_depth_r  <= '0;
            out_flags_r  <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.chosen_way   = out_way_r;
  assign out_ch.bucket_index = out_bucket_r;
  assign out_ch.entry_depth  = out_depth_r;
  assign out_ch.entry_flags  = out_flags_r;

endmodule

FILE: src/transposition_table_probe_replace.sv
// a command passes the queue, the row read and the evaluation before its result is registered
// the back end takes no new command until the read-modify-write of the previous bucket row
//   in the single bucket memory is done; a clear sweeps every row, one row a cycle
// reset: synchronous active-low rst_n; current_age returns to 0, age_field_mask to 248;
//   the store is then swept to empty, one row a cycle, with in_ch.ready low;
//   configuration writes are taken throughout
module transposition_table_probe_replace #(
  parameter int BUCKET_BITS = 10,
  parameter int WAYS        = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  ttpr_in_if.sink            in_ch,
  ttpr_out_if.source         out_ch,
  input  logic               cfg_we,
  input  ttpr_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import ttpr_pkg::*;

  localparam int ITEM_W = $bits(item_t) + BUCKET_BITS;

  // configuration registers
  logic [7:0]  current_age_r;
  logic [7:0]  age_field_r;
  age_cfg_t    cfg;

  // front to queue
  logic              push;
  logic [ITEM_W-1:0] push_data;
  logic              q_full;

  // queue to back
  logic              q_valid;
  logic              q_pop;
  logic [ITEM_W-1:0] q_data;
  logic              init_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_age_r <= AGE_RESET;
      age_field_r   <= AGE_FIELD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURRENT_AGE: current_age_r <= cfg_wdata;
        CFG_AGE_FIELD:   age_field_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg.current_age = current_age_r;
  assign cfg.age_field   = age_field_r;

  // front: decode and split the key, hold off until the reset sweep is over
  ttpr_front #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_front (
    .in_ch     (in_ch),
    .init_done (init_done),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // short queue so the front keeps taking commands while the back works
  ttpr_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  // back: bucket memory, probe/replace/store evaluation, clear sweep, result register
  ttpr_back #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/sv/transposition_table_probe_replace_tb.sv
// self-checking testbench of the transposition table probe/replace block
module transposition_table_probe_replace_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttpr_pkg::*;

  localparam int BUCKETS       = 1024;
  localparam int WAYS_N        = 3;
  localparam int QUIET_LIMIT   = 6000;  // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES = 1100;  // idle stretch between phases
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off to back the block up
  localparam int PHASE_ITEMS   = 204;
  localparam int NUM_PHASES    = 7;

  // one command as it goes onto the input channel
  typedef struct {
    cmd_t              cmd;
    logic [63:0]       key;
    logic [1:0]        way;
    logic signed [7:0] depth;
    logic [7:0]        flags;
  } cmd_item_t;

  // one result as it should come out of the result channel
  typedef struct {
    logic              found;
    logic [1:0]        way;
    logic [9:0]        bucket;
    logic signed [7:0] depth;
    logic [7:0]        flags;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_index = CFG_CURRENT_AGE;
  logic [7:0] cfg_wdata = 8'd0;

  ttpr_in_if  in_ch ();
  ttpr_out_if out_ch ();

  transposition_table_probe_replace DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: its own copy of the table and the age registers
  entry_t     tt_mem [BUCKETS][WAYS_N];
  logic [7:0] age_now;
  logic [7:0] age_field;

  cmd_item_t cmd_backlog [$];    // commands not yet on the channel
  result_t   result_due_q [$];   // results predicted for accepted commands, oldest first

  int errors = 0;
  int accepted = 0;
  int n_results = 0;
  int n_probe = 0, n_hit = 0, n_pick = 0, n_pick_rank = 0;
  int n_store = 0, n_store_bad = 0, n_clear = 0;

  // idling controls, set per phase by the stimulus
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit calm = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  logic [9:0] hot_buckets [8] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd511, 10'd512, 10'd1022,
                                  10'd1023};
  logic [15:0] hot_tags [5] = '{16'hFFFF, 16'h8001, 16'h1234, 16'h00FF, 16'hABCD};

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // depth minus relative age, the replacement score of one way
  function automatic int slot_rank(entry_t e);
    logic [7:0] rel;
    rel = (age_now - (e.flags & age_field)) & age_field;
    return int'($signed(e.depth)) - int'(rel);
  endfunction

  // applies one command to the table copy and returns the result it causes
  function automatic result_t lookup_and_update(cmd_item_t it);
    result_t     r;
    int          b;
    int          pick;
    logic [15:0] tag;
    logic [7:0]  f;
    bit          done;
    b        = int'(it.key[9:0]);
    tag      = it.key[63:48];
    r.found  = 1'b0;
    r.way    = 2'd0;
    r.bucket = it.key[9:0];
    r.depth  = 8'sd0;
    r.flags  = 8'd0;
    case (it.cmd)
      CMD_PROBE: begin
        n_probe++;
        done = 1'b0;
        for (int w = 0; w < WAYS_N; w++) begin
          if (!done && tt_mem[b][w].tag == tag) begin
            f = tt_mem[b][w].flags;
            // stale age bits: renew them, keep the bound flags
            if ((f & age_field) != age_now) begin
              f = age_now + (f & ~age_field);
              tt_mem[b][w].flags = f;
            end
            r.found = 1'b1;
            r.way   = 2'(w);
            r.depth = tt_mem[b][w].depth;
            r.flags = f;
            done    = 1'b1;
            n_hit++;
          end
        end
      end
      CMD_REPLACE: begin
        n_pick++;
        pick = -1;
        for (int w = 0; w < WAYS_N; w++) begin
          if (pick < 0 && (tt_mem[b][w].tag == 16'd0 || tt_mem[b][w].tag == tag)) pick = w;
        end
        if (pick >= 0) begin
          r.found = 1'b1;
        end else begin
          // earliest way with the lowest score wins ties
          pick = 0;
          for (int w = 1; w < WAYS_N; w++) begin
            if (slot_rank(tt_mem[b][pick]) > slot_rank(tt_mem[b][w])) pick = w;
          end
          n_pick_rank++;
        end
        r.way   = 2'(pick);
        r.depth = tt_mem[b][pick].depth;
        r.flags = tt_mem[b][pick].flags;
      end
      CMD_STORE: begin
        n_store++;
        r.way = it.way;
        if (it.way < WAYS_N) begin
          tt_mem[b][it.way].tag   = tag;
          tt_mem[b][it.way].depth = it.depth;
          tt_mem[b][it.way].flags = it.flags;
          r.found = 1'b1;
          r.depth = it.depth;
          r.flags = it.flags;
        end else begin
          n_store_bad++;
        end
      end
      default: begin
        n_clear++;
        foreach (tt_mem[i, j]) tt_mem[i][j] = '0;
      end
    endcase
    return r;
  endfunction

  function automatic void field_check(string what, logic signed [63:0] e,
                                      logic signed [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, e, a);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: predicts on every accepted transfer, then loads the next item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    cmd_item_t cur;
    cmd_item_t nxt;
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.command      <= CMD_PROBE;
      in_ch.position_key <= 64'd0;
      in_ch.store_way    <= 2'd0;
      in_ch.store_depth  <= 8'sd0;
      in_ch.store_flags  <= 8'd0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur.cmd   = cmd_t'(in_ch.command);
        cur.key   = in_ch.position_key;
        cur.way   = in_ch.store_way;
        cur.depth = in_ch.store_depth;
        cur.flags = in_ch.store_flags;
        result_due_q.push_back(lookup_and_update(cur));
        accepted++;
      end
      // channel free after this edge: idle, offer the next command, or go quiet
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.command      <= nxt.cmd;
          in_ch.position_key <= nxt.key;
          in_ch.store_way    <= nxt.way;
          in_ch.store_depth  <= nxt.depth;
          in_ch.store_flags  <= nxt.flags;
          if (src_idle_en && !calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (result_due_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual found=%0d way=%0d bucket=%0d",
                 $time, out_ch.found, out_ch.chosen_way, out_ch.bucket_index);
      end else begin
        want = result_due_q.pop_front();
        field_check("found", 64'(want.found), 64'(out_ch.found));
        field_check("chosen_way", 64'(want.way), 64'(out_ch.chosen_way));
        field_check("bucket_index", 64'(want.bucket), 64'(out_ch.bucket_index));
        field_check("entry_depth", 64'(want.depth), 64'(out_ch.entry_depth));
        field_check("entry_flags", 64'(want.flags), 64'(out_ch.entry_flags));
      end
    end
    // one long hold-off early in the run so the block fills and stalls its input
    if (!hold_done && accepted >= 150) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else if (sink_idle_en && !calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // key with the given tag and bucket; the bits between them are random
  function automatic logic [63:0] mk_key(logic [15:0] tag, logic [9:0] bucket);
    logic [63:0] k;
    k        = {$urandom, $urandom};
    k[63:48] = tag;
    k[9:0]   = bucket;
    return k;
  endfunction

  // keys gather on a few buckets and tags so that buckets fill and get contested
  function automatic logic [63:0] random_key();
    logic [9:0]  b;
    logic [15:0] t;
    int          r;
    b = ($urandom_range(0, 9) == 0) ? 10'($urandom) : hot_buckets[$urandom_range(0, 7)];
    r = $urandom_range(0, 19);
    if (r == 0) t = 16'd0;
    else if (r <= 2) t = 16'($urandom);
    else t = hot_tags[$urandom_range(0, 4)];
    return mk_key(t, b);
  endfunction

  task automatic push_cmd(cmd_t c, logic [63:0] k, logic [1:0] w, logic [7:0] d,
                          logic [7:0] f);
    cmd_item_t it;
    it.cmd   = c;
    it.key   = k;
    it.way   = w;
    it.depth = d;
    it.flags = f;
    cmd_backlog.push_back(it);
  endtask

  // store with a random way (sometimes out of range), depth and flag byte
  task automatic push_random_store(logic [63:0] k);
    logic [1:0] w;
    logic [7:0] d;
    logic [7:0] f;
    w = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: d = 8'h80;
          1: d = 8'hFF;
          2: d = 8'h00;
          3: d = 8'h01;
          default: d = 8'h7F;
        endcase
      end
      1: d = 8'($urandom_range(0, 3));
      default: d = 8'($urandom);
    endcase
    // a third of the stores already carry the current age
    if ($urandom_range(0, 2) == 0) f = (age_now & age_field) | (8'($urandom) & ~age_field);
    else f = 8'($urandom);
    push_cmd(CMD_STORE, k, w, d, f);
  endtask

  task automatic gen_phase(int n);
    int          made;
    logic [63:0] k;
    cmd_t        c;
    made = 0;
    while (made < n) begin
      k = random_key();
      if ($urandom_range(0, 3) != 0) begin
        // usual engine pattern: probe, pick a way, store, probe again
        push_cmd(CMD_PROBE, k, 2'($urandom), 8'($urandom), 8'($urandom));
        push_cmd(CMD_REPLACE, k, 2'($urandom), 8'($urandom), 8'($urandom));
        push_random_store(k);
        push_cmd(CMD_PROBE, k, 2'($urandom), 8'($urandom), 8'($urandom));
        made += 4;
      end else begin
        // stray commands, now and then a clear, sometimes on a fully random key
        if ($urandom_range(0, 19) == 0) c = CMD_CLEAR;
        else c = cmd_t'(2'($urandom_range(0, 2)));
        if ($urandom_range(0, 3) == 0) k = {$urandom, $urandom};
        if (c == CMD_STORE) push_random_store(k);
        else push_cmd(c, k, 2'($urandom), 8'($urandom), 8'($urandom));
        made++;
      end
    end
  endtask

  task automatic wait_drained(int settle);
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_ch.valid || result_due_q.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CURRENT_AGE) age_now = v;
    else age_field = v;
  endtask

  initial begin
    logic [7:0]  ages  [NUM_PHASES];
    logic [7:0]  masks [NUM_PHASES];
    logic [63:0] all_ones;

    age_now   = AGE_RESET;
    age_field = AGE_FIELD_RESET;
    foreach (tt_mem[i, j]) tt_mem[i][j] = '0;
    all_ones = '1;

    // age settings per phase: plain, all-ones, no age bits, age outside the mask, random
    ages  = '{8'd8,   8'd255, 8'd0, 8'h37, 8'd128, 8'($urandom), 8'($urandom)};
    masks = '{8'd248, 8'd255, 8'd0, 8'hF8, 8'h7F,  8'($urandom), 8'($urandom)};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, at reset settings (age 0, mask 248)
    push_cmd(CMD_PROBE,   mk_key(16'h1234, 10'd5),    2'd0, 8'h00, 8'h00); // miss on empty
    push_cmd(CMD_PROBE,   mk_key(16'h0000, 10'd1023), 2'd0, 8'h00, 8'h00); // tag zero hits empty
    push_cmd(CMD_REPLACE, mk_key(16'h1234, 10'd5),    2'd0, 8'h00, 8'h00); // empty way
    push_cmd(CMD_STORE,   mk_key(16'hA000, 10'd5),    2'd0, 8'h80, 8'hFF);
    push_cmd(CMD_STORE,   mk_key(16'hB000, 10'd5),    2'd1, 8'h7F, 8'h00);
    push_cmd(CMD_STORE,   mk_key(16'hC000, 10'd5),    2'd2, 8'h00, 8'h07);
    push_cmd(CMD_STORE,   mk_key(16'hD000, 10'd5),    2'd3, 8'h55, 8'hAA); // way out of range
    push_cmd(CMD_PROBE,   mk_key(16'hB000, 10'd5),    2'd3, 8'hFF, 8'hFF); // hit, age current
    push_cmd(CMD_PROBE,   mk_key(16'hA000, 10'd5),    2'd1, 8'h01, 8'h01); // hit, age renewed
    push_cmd(CMD_REPLACE, mk_key(16'hD000, 10'd5),    2'd0, 8'h00, 8'h00); // full, by score
    push_cmd(CMD_REPLACE, mk_key(16'hC000, 10'd5),    2'd0, 8'h00, 8'h00); // matching way
    push_cmd(CMD_STORE,   all_ones,                   2'd2, 8'h7F, 8'h80);
    push_cmd(CMD_PROBE,   all_ones,                   2'd0, 8'h00, 8'h00);
    push_cmd(CMD_REPLACE, mk_key(16'h0001, 10'd1023), 2'd0, 8'h00, 8'h00);
    push_cmd(CMD_CLEAR,   all_ones,                   2'd3, 8'hFF, 8'hFF);
    push_cmd(CMD_PROBE,   mk_key(16'hA000, 10'd5),    2'd0, 8'h00, 8'h00); // gone after clear
    push_cmd(CMD_PROBE,   mk_key(16'h0000, 10'd0),    2'd0, 8'h00, 8'h00);
    push_cmd(CMD_STORE,   mk_key(16'h0000, 10'd0),    2'd0, 8'h05, 8'h10); // tag zero stored
    push_cmd(CMD_REPLACE, mk_key(16'h4444, 10'd0),    2'd0, 8'h00, 8'h00);
    push_cmd(CMD_CLEAR,   64'd0,                      2'd0, 8'h00, 8'h00);
    wait_drained(SETTLE_CYCLES);

    // random phases, each under its own age setting; the last one runs without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_CURRENT_AGE, ages[p]);
      write_reg(CFG_AGE_FIELD, masks[p]);
      src_idle_en  = (p != 2);
      sink_idle_en = (p != 4);
      calm         = (p == NUM_PHASES - 1);
      gen_phase(PHASE_ITEMS);
      wait_drained((p == NUM_PHASES - 1) ? 20 : SETTLE_CYCLES);
    end

    if (result_due_q.size() != 0) errors++;
    $display("run: %0d commands, %0d results; %0d probes with %0d hits, %0d way picks",
             accepted, n_results, n_probe, n_hit, n_pick);
    $display("run: %0d picked by score, %0d stores (%0d out of range), %0d clears, %0d ages",
             n_pick_rank, n_store, n_store_bad, n_clear, NUM_PHASES + 1);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
